/* rtl/ptqd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptqd_pkg
// Shared types and constants of the priority task queue dispatcher.
// ----------------------------------------------------------------------------
package ptqd_pkg;

    localparam int QUEUE_DEPTH_DEF = 32;

    localparam int ID_W    = 8;
    localparam int PRIO_W  = 8;
    localparam int BURST_W = 16;
    localparam int TIME_W  = 21;
    localparam int STAT_W  = 2;

    // slave tdata: task_id, prio, burst_len
    localparam int IN_DATA_W  = 32;
    localparam int IN_USER_W  = 1;
    // master tdata: out_task_id, out_prio, out_burst, start_time, finish_time, pad
    localparam int OUT_FLD_W  = ID_W + PRIO_W + BURST_W + 2 * TIME_W;
    localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W  = OUT_DATA_W - OUT_FLD_W;

    localparam logic KIND_ADD  = 1'b0;
    localparam logic KIND_DISP = 1'b1;

    localparam logic [STAT_W-1:0] STAT_DISPATCHED = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY      = 2'd1;
    localparam logic [STAT_W-1:0] STAT_REJECTED   = 2'd2;

    // packed so that the slave tdata maps onto it directly
    typedef struct packed {
        logic [BURST_W-1:0] burst;
        logic [PRIO_W-1:0]  prio;
        logic [ID_W-1:0]    id;
    } t_entry;

endpackage

/* rtl/priority_task_queue_dispatch.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_task_queue_dispatch
// Task queue kept sorted by descending priority in one synchronous memory,
// arrival order kept among equal priorities; a dispatch drains it in order.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tuser: kind; tdata: id, prio, burst
//  m_axis    out  m_axis_tvalid / m_axis_tready  tuser: status; tdata: task + times;
//                                                tlast: last result of the item
//
//  add: written straight to slot 0 on an empty queue, else entries of lower priority
//  shift up one place (one read-modify-write per cycle) and the new entry fills the hole.
//  dispatch: one result per cycle while m_axis takes beats, from a registered memory read.
//  reset clears the state, occupancy count and output valid; memory contents are left as they are.
//  a new item is taken only when the block is idle and the result register
//  can take a beat; a stalled m_axis holds the drain in place.
// ----------------------------------------------------------------------------
module priority_task_queue_dispatch #(
    parameter int QUEUE_DEPTH = ptqd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [7:0] task_id, [15:8] prio, [31:16] burst_len
    input  logic [ptqd_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // [0] kind
    input  logic [ptqd_pkg::IN_USER_W-1:0]  s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [7:0] out_task_id, [15:8] out_prio, [31:16] out_burst,
    // [52:32] start_time, [73:53] finish_time, [79:74] zero
    output logic [ptqd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // [1:0] status
    output logic [ptqd_pkg::STAT_W-1:0]     m_axis_tuser,
    output logic                            m_axis_tlast
);
    import ptqd_pkg::*;

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_INS,
        S_HEAD,
        S_DISP
    } t_state;

    t_state              r_state;
    logic [CNT_W-1:0]    r_occ;
    t_entry              r_new;
    logic [IDX_W-1:0]    r_ins_pos;
    logic [IDX_W-1:0]    r_rd_idx;
    logic [CNT_W-1:0]    r_rd_left;
    logic                r_pend;
    logic                r_pend_last;
    logic [TIME_W-1:0]   r_clock;

    logic                r_out_valid;
    logic [STAT_W-1:0]   r_out_status;
    t_entry              r_out_entry;
    logic [TIME_W-1:0]   r_out_start;
    logic [TIME_W-1:0]   r_out_finish;
    logic                r_out_last;

    t_entry              mem [QUEUE_DEPTH];
    t_entry              r_rd_q;

    logic                out_free;
    logic                in_acc;
    logic                q_full;
    logic                consume;
    logic                issue;
    logic                new_goes_here;
    logic [TIME_W-1:0]   fin_time;
    t_entry              in_entry;

    logic                mem_rd_en;
    logic [IDX_W-1:0]    mem_rd_addr;
    logic                mem_wr_en;
    logic [IDX_W-1:0]    mem_wr_addr;
    t_entry              mem_wr_data;

    assign in_entry      = t_entry'(s_axis_tdata);
    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && out_free;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign q_full        = (r_occ == CNT_W'(QUEUE_DEPTH));
    assign consume       = (r_state == S_DISP) && r_pend && out_free;
    assign issue         = (r_state == S_DISP) && (r_rd_left != '0) && (!r_pend || consume);
    // entry below the hole stays put when its priority is not lower
    assign new_goes_here = (r_rd_q.prio >= r_new.prio);
    assign fin_time      = TIME_W'(r_clock + TIME_W'(r_rd_q.burst));

    // memory port control
    always_comb begin
        mem_rd_en   = 1'b0;
        mem_rd_addr = r_rd_idx;
        mem_wr_en   = 1'b0;
        mem_wr_addr = r_ins_pos;
        mem_wr_data = r_new;
        case (r_state)
            S_IDLE: begin
                if (in_acc && (s_axis_tuser[0] == KIND_ADD) && !q_full) begin
                    if (r_occ == '0) begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = '0;
                        mem_wr_data = in_entry;
                    end else begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = IDX_W'(r_occ - 1'b1);
                    end
                end
            end
            S_INS: begin
                // fetch the next lower slot while this one is resolved
                mem_rd_en   = 1'b1;
                mem_rd_addr = IDX_W'(r_ins_pos - 2'd2);
                mem_wr_en   = 1'b1;
                mem_wr_addr = r_ins_pos;
                mem_wr_data = new_goes_here ? r_new : r_rd_q;
            end
            S_HEAD: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = '0;
                mem_wr_data = r_new;
            end
            S_DISP: begin
                mem_rd_en   = issue;
                mem_rd_addr = r_rd_idx;
            end
            default: begin
                mem_rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_wr_en) begin
            mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_rd_en) begin
            r_rd_q <= mem[mem_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_occ       <= '0;
            r_rd_left   <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_new <= in_entry;
                        if (s_axis_tuser[0] == KIND_ADD) begin
                            if (q_full) begin
                                r_out_valid  <= 1'b1;
                                r_out_status <= STAT_REJECTED;
                                r_out_entry  <= '0;
                                r_out_start  <= '0;
                                r_out_finish <= '0;
                                r_out_last   <= 1'b1;
                            end else if (r_occ == '0) begin
                                r_occ <= CNT_W'(1);
                            end else begin
                                r_ins_pos <= IDX_W'(r_occ);
                                r_state   <= S_INS;
                            end
                        end else if (r_occ == '0) begin
                            r_out_valid  <= 1'b1;
                            r_out_status <= STAT_EMPTY;
                            r_out_entry  <= '0;
                            r_out_start  <= '0;
                            r_out_finish <= '0;
                            r_out_last   <= 1'b1;
                        end else begin
                            r_rd_idx  <= '0;
                            r_rd_left <= r_occ;
                            r_pend    <= 1'b0;
                            r_clock   <= '0;
                            r_state   <= S_DISP;
                        end
                    end
                end
                S_INS: begin
                    if (new_goes_here) begin
                        r_occ   <= CNT_W'(r_occ + 1'b1);
                        r_state <= S_IDLE;
                    end else if (r_ins_pos == IDX_W'(1)) begin
                        r_state <= S_HEAD;
                    end else begin
                        r_ins_pos <= IDX_W'(r_ins_pos - 1'b1);
                    end
                end
                S_HEAD: begin
                    r_occ   <= CNT_W'(r_occ + 1'b1);
                    r_state <= S_IDLE;
                end
                S_DISP: begin
                    if (issue) begin
                        r_rd_idx    <= IDX_W'(r_rd_idx + 1'b1);
                        r_rd_left   <= CNT_W'(r_rd_left - 1'b1);
                        r_pend      <= 1'b1;
                        r_pend_last <= (r_rd_left == CNT_W'(1));
                    end else if (consume) begin
                        r_pend <= 1'b0;
                    end
                    if (consume) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= STAT_DISPATCHED;
                        r_out_entry  <= r_rd_q;
                        r_out_start  <= r_clock;
                        r_out_finish <= fin_time;
                        r_out_last   <= r_pend_last;
                        r_clock      <= fin_time;
                        if (r_pend_last) begin
                            r_occ   <= '0;
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_out_finish, r_out_start,
                            r_out_entry.burst, r_out_entry.prio, r_out_entry.id};

endmodule

/* tb/ptqd_dispatch_monitor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptqd_dispatch_monitor
// Watches both stream channels of the priority task queue. Keeps its own
// sorted copy of the queue, works out the beats each accepted item must give,
// and compares every result beat field by field against the oldest one due.
// ----------------------------------------------------------------------------
module ptqd_dispatch_monitor #(
    parameter int QUEUE_DEPTH = ptqd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    // [7:0] task_id, [15:8] prio, [31:16] burst_len
    input  logic [ptqd_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // [0] kind
    input  logic [ptqd_pkg::IN_USER_W-1:0]  i_s_tuser,
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    // [7:0] id, [15:8] prio, [31:16] burst, [52:32] start, [73:53] finish, pad
    input  logic [ptqd_pkg::OUT_DATA_W-1:0] i_m_tdata,
    // [1:0] status
    input  logic [ptqd_pkg::STAT_W-1:0]     i_m_tuser,
    input  logic                            i_m_tlast,
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_result_count,
    output int                              o_dispatch_count,
    output int                              o_empty_count,
    output int                              o_reject_count
);
    import ptqd_pkg::*;

    typedef struct packed {
        logic [OUT_PAD_W-1:0] pad;
        logic [TIME_W-1:0]    finish;
        logic [TIME_W-1:0]    start;
        logic [BURST_W-1:0]   burst;
        logic [PRIO_W-1:0]    prio;
        logic [ID_W-1:0]      id;
    } t_out_beat;

    typedef struct {
        logic [STAT_W-1:0] status;
        t_entry            task_info;
        logic [TIME_W-1:0] start;
        logic [TIME_W-1:0] finish;
        logic              last;
    } t_sched_result;

    t_entry        sched_queue[QUEUE_DEPTH];
    int            queued;
    t_sched_result due_results[$];
    int            mismatches;
    int            results_seen;
    int            dispatched;
    int            empties;
    int            rejects;

    initial begin
        queued       = 0;
        mismatches   = 0;
        results_seen = 0;
        dispatched   = 0;
        empties      = 0;
        rejects      = 0;
        o_fail_count     = 0;
        o_pending        = 0;
        o_result_count   = 0;
        o_dispatch_count = 0;
        o_empty_count    = 0;
        o_reject_count   = 0;
    end

    function automatic void push_result(logic [STAT_W-1:0] status, t_entry task_info,
                                        logic [TIME_W-1:0] start,
                                        logic [TIME_W-1:0] finish, logic last);
        t_sched_result r;
        r.status    = status;
        r.task_info = task_info;
        r.start     = start;
        r.finish    = finish;
        r.last      = last;
        due_results.push_back(r);
    endfunction

    // sorted insert on add, full drain on dispatch
    function automatic void schedule_item(logic kind, t_entry item);
        int                pos;
        logic [TIME_W-1:0] clock;
        logic [TIME_W-1:0] fin;
        if (kind == KIND_ADD) begin
            if (queued >= QUEUE_DEPTH) begin
                push_result(STAT_REJECTED, '0, '0, '0, 1'b1);
            end else begin
                pos = 0;
                // equal priorities stay in arrival order
                while (pos < queued && sched_queue[pos].prio >= item.prio)
                    pos++;
                for (int i = queued; i > pos; i--)
                    sched_queue[i] = sched_queue[i-1];
                sched_queue[pos] = item;
                queued++;
            end
        end else if (queued == 0) begin
            push_result(STAT_EMPTY, '0, '0, '0, 1'b1);
        end else begin
            clock = '0;
            for (int k = 0; k < queued; k++) begin
                fin = clock + sched_queue[k].burst;
                push_result(STAT_DISPATCHED, sched_queue[k], clock, fin, k == queued - 1);
                clock = fin;
            end
            queued = 0;
        end
    endfunction

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    function automatic void check_result();
        t_out_beat     beat;
        t_sched_result want;
        beat = t_out_beat'(i_m_tdata);
        results_seen++;
        if (due_results.size() == 0) begin
            $display("%0t: result beat with nothing expected, got status %0h data %0h",
                     $time, i_m_tuser, i_m_tdata);
            mismatches++;
        end else begin
            want = due_results.pop_front();
            case (want.status)
                STAT_DISPATCHED: dispatched++;
                STAT_EMPTY:      empties++;
                default:         rejects++;
            endcase
            compare_field("status", 32'(want.status), 32'(i_m_tuser));
            compare_field("task_id", 32'(want.task_info.id), 32'(beat.id));
            compare_field("prio", 32'(want.task_info.prio), 32'(beat.prio));
            compare_field("burst", 32'(want.task_info.burst), 32'(beat.burst));
            compare_field("start_time", 32'(want.start), 32'(beat.start));
            compare_field("finish_time", 32'(want.finish), 32'(beat.finish));
            compare_field("last", 32'(want.last), 32'(i_m_tlast));
            compare_field("pad", '0, 32'(beat.pad));
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            queued = 0;
        end else begin
            // an output beat never belongs to an item taken at the same edge
            if (i_m_tvalid && i_m_tready)
                check_result();
            if (i_s_tvalid && i_s_tready)
                schedule_item(i_s_tuser[0], t_entry'(i_s_tdata));
        end
        o_fail_count     <= mismatches;
        o_pending        <= due_results.size();
        o_result_count   <= results_seen;
        o_dispatch_count <= dispatched;
        o_empty_count    <= empties;
        o_reject_count   <= rejects;
    end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the priority task queue dispatcher: directed
// corner items, then random add/dispatch batches with random idling on both
// sides, a long output stall and a quiet tail; checking is in the monitor.
// ----------------------------------------------------------------------------
module tb_top;
    import ptqd_pkg::*;

    localparam int QUEUE_DEPTH    = QUEUE_DEPTH_DEF;
    localparam int ITEM_TARGET    = 460;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 60;

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // [7:0] task_id, [15:8] prio, [31:16] burst_len
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    // [0] kind
    logic [IN_USER_W-1:0]  s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [7:0] id, [15:8] prio, [31:16] burst, [52:32] start, [73:53] finish, pad
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    // [1:0] status
    logic [STAT_W-1:0]     m_axis_tuser;
    logic                  m_axis_tlast;

    int fail_count;
    int pending;
    int result_count;
    int dispatch_count;
    int empty_count;
    int reject_count;

    int items_sent  = 0;
    int idle_cycles = 0;
    bit gaps_on     = 1'b1;
    bit quiet_tail  = 1'b0;
    bit rx_hold_req = 1'b0;

    priority_task_queue_dispatch #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    ptqd_dispatch_monitor #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_dispatch_monitor (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_tvalid      (s_axis_tvalid),
        .i_s_tready      (s_axis_tready),
        .i_s_tdata       (s_axis_tdata),
        .i_s_tuser       (s_axis_tuser),
        .i_m_tvalid      (m_axis_tvalid),
        .i_m_tready      (m_axis_tready),
        .i_m_tdata       (m_axis_tdata),
        .i_m_tuser       (m_axis_tuser),
        .i_m_tlast       (m_axis_tlast),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_result_count  (result_count),
        .o_dispatch_count(dispatch_count),
        .o_empty_count   (empty_count),
        .o_reject_count  (reject_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // result side: random ready/stall bursts, one long hold on request
    initial begin
        @(posedge i_clk);
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
            end else if (quiet_tail || $urandom_range(0, 2) != 0) begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end
        end
    end

    // ends the run when neither channel moves a beat for too long
    initial begin
        forever begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // valid stays high from one beat to the next unless a gap is inserted
    task automatic send_item(logic kind, logic [ID_W-1:0] id, logic [PRIO_W-1:0] prio,
                             logic [BURST_W-1:0] burst);
        if (gaps_on && !quiet_tail && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= t_entry'{burst: burst, prio: prio, id: id};
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic run_batch(int n_adds, bit with_dispatch);
        bit                 tie_heavy;
        bit                 long_bursts;
        logic [PRIO_W-1:0]  prio;
        logic [BURST_W-1:0] burst;
        tie_heavy   = $urandom_range(0, 2) == 0;
        long_bursts = $urandom_range(0, 3) == 0;
        for (int i = 0; i < n_adds; i++) begin
            prio = PRIO_W'(tie_heavy ? $urandom_range(0, 3) : $urandom_range(0, 255));
            case ($urandom_range(0, 7))
                0:       burst = '0;
                1:       burst = '1;
                default: burst = BURST_W'($urandom_range(0, 65535));
            endcase
            if (long_bursts)
                burst = '1;
            send_item(KIND_ADD, ID_W'($urandom_range(0, 255)), prio, burst);
        end
        // payload of a dispatch is ignored but still toggled
        if (with_dispatch)
            send_item(KIND_DISP, ID_W'($urandom_range(0, 255)),
                      PRIO_W'($urandom_range(0, 255)), BURST_W'($urandom_range(0, 65535)));
    endtask

    task automatic random_batch();
        int pick;
        gaps_on = $urandom_range(0, 2) != 0;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            run_batch(0, 1'b1);
        else if (pick < 25)
            run_batch($urandom_range(QUEUE_DEPTH, QUEUE_DEPTH + 4), 1'b1);
        else if (pick < 45)
            run_batch($urandom_range(9, QUEUE_DEPTH - 1), $urandom_range(0, 6) != 0);
        else
            run_batch($urandom_range(0, 8), $urandom_range(0, 6) != 0);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty drain, field extremes, priority ties, drain, empty again
        send_item(KIND_DISP, '0, '0, '0);
        send_item(KIND_ADD, 8'h00, 8'h00, 16'h0000);
        send_item(KIND_ADD, 8'hff, 8'hff, 16'hffff);
        send_item(KIND_ADD, 8'h5a, 8'h80, 16'h0001);
        send_item(KIND_ADD, 8'ha5, 8'h80, 16'hffff);
        send_item(KIND_ADD, 8'h01, 8'hff, 16'h0000);
        send_item(KIND_ADD, 8'h02, 8'h00, 16'h8000);
        send_item(KIND_ADD, 8'h80, 8'h01, 16'h00ff);
        send_item(KIND_ADD, 8'h7f, 8'h7f, 16'h7fff);
        send_item(KIND_DISP, 8'hff, 8'hff, 16'hffff);
        send_item(KIND_DISP, '0, '0, '0);
        wait_drained();

        // fill past capacity so the last adds come back rejected
        run_batch(QUEUE_DEPTH + 2, 1'b1);
        while (items_sent < 200)
            random_batch();

        // long output stall with a full drain pending and the sender still offering
        wait_drained();
        gaps_on = 1'b0;
        run_batch(12, 1'b0);
        rx_hold_req = 1'b1;
        // the hold has begun once the receiver takes the request
        while (rx_hold_req)
            @(posedge i_clk);
        send_item(KIND_DISP, '0, '0, '0);
        run_batch(8, 1'b1);

        wait_drained();
        while (items_sent < 400)
            random_batch();
        wait_drained();

        quiet_tail = 1'b1;
        while (items_sent < ITEM_TARGET)
            random_batch();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("sent %0d items, checked %0d result beats", items_sent, result_count);
        $display("tasks dispatched %0d, empty drains %0d, full-queue rejects %0d",
                 dispatch_count, empty_count, reject_count);
        if (fail_count == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
